// ===== src/lpl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lpl_pkg
// Shared constants and types for the look-ahead peak limiter.
// ---------------------------------------------------------------------------
package lpl_pkg;
    localparam int LOOKAHEAD_LOG2_DEF = 8;
    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int COEF_SHIFT         = 24;
    localparam logic [23:0] COEF_REL_KEEP = 24'd16775538;
    localparam logic [23:0] COEF_REL_ADD  = 24'd1678;
    localparam logic [23:0] COEF_TGT_NEW  = 24'd1676044;
    localparam logic [23:0] COEF_TGT_KEEP = 24'd15097817;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_TREE_RD,
        ST_TREE_CMP,
        ST_DIV1,
        ST_MREL,
        ST_MTGT1,
        ST_MTGT2,
        ST_SMOOTH,
        ST_SCALE,
        ST_CHECK,
        ST_DIV2,
        ST_SCALE2,
        ST_ROUND2,
        ST_OUT
    } t_state;
endpackage
`default_nettype wire

// ===== src/lpl_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lpl_div
// Restoring divider, one quotient bit per cycle: (num << FRAC) / den.
// ---------------------------------------------------------------------------
module lpl_div
    import lpl_pkg::*;
#(
    parameter int FRAC = SAMPLE_BITS_DEF - 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [FRAC-1:0]  i_num,
    input  wire logic [FRAC:0]    i_den,
    output logic                  o_busy,
    output logic [2*FRAC-1:0]     o_quot
);
    localparam int QW = 2 * FRAC;
    localparam int CW = $clog2(QW + 1);

    logic [QW-1:0] r_dividend, n_dividend;
    logic [FRAC:0] r_rem, n_rem;
    logic [FRAC:0] r_den;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic [FRAC+1:0] w_trial;

    always_comb begin
        n_dividend = r_dividend;
        n_rem      = r_rem;
        n_cnt      = r_cnt;
        n_busy     = r_busy;
        w_trial    = {r_rem, r_dividend[QW-1]} - {1'b0, r_den};
        if (i_start) begin
            n_dividend = {i_num, FRAC'(0)};
            n_rem      = '0;
            n_cnt      = CW'(QW);
            n_busy     = 1'b1;
        end else if (r_busy) begin
            if (!w_trial[FRAC+1]) begin
                n_rem      = w_trial[FRAC:0];
                n_dividend = {r_dividend[QW-2:0], 1'b1};
            end else begin
                n_rem      = {r_rem[FRAC-1:0], r_dividend[QW-1]};
                n_dividend = {r_dividend[QW-2:0], 1'b0};
            end
            n_cnt  = r_cnt - 1'b1;
            n_busy = (r_cnt != CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_dividend <= n_dividend;
        r_rem      <= n_rem;
        if (i_start) r_den <= i_den;
    end

    assign o_busy = r_busy;
    assign o_quot = r_dividend;
endmodule
`default_nettype wire

// ===== src/lookahead_peak_limiter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lookahead_peak_limiter
// Look-ahead limiter: delay line, sliding max tree, smoothed gain.
// ---------------------------------------------------------------------------
// Channel  | Dir | Contents
// s_axis   | in  | tdata: sample_in (SAMPLE_BITS, signed)
// m_axis   | out | tdata: sample_out (SAMPLE_BITS, signed)
// cfg      | in  | gate_level (SAMPLE_BITS-1)
//
// When the limiter is idle, a sample runs through the smoothing, scaling and
// check states to the output register; when active, a tree walk and, above
// the gate, a division come first, and a second division may follow the
// check. One multiplier is shared. When the limiter turns active, the tree
// is swept clear. After reset a clearing pass runs before s_axis_tready.
// Not ready while a sample is in work; the output register holds on stall.
// ---------------------------------------------------------------------------
module lookahead_peak_limiter
    import lpl_pkg::*;
#(
    parameter int LOOKAHEAD_LOG2 = LOOKAHEAD_LOG2_DEF,
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [SAMPLE_BITS-1:0] s_axis_tdata,  // [SB-1:0] sample_in
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [SAMPLE_BITS-1:0]      m_axis_tdata,  // [SB-1:0] sample_out
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [SAMPLE_BITS-2:0] i_cfg_data
);
    localparam int FRAC = SAMPLE_BITS - 1;
    localparam int L    = LOOKAHEAD_LOG2;
    localparam int WIN  = 1 << L;
    localparam int TD   = 2 * WIN;
    localparam int NW   = L + 1;
    localparam int GW   = FRAC + 1;
    localparam int LW   = $clog2(L + 1);
    localparam int BW   = (GW > COEF_SHIFT) ? GW : COEF_SHIFT;
    localparam int PW   = GW + BW;
    localparam logic [GW-1:0] UNITY = GW'(1) << FRAC;
    localparam logic [FRAC-1:0] MAG_MAX = '1;
    localparam logic [FRAC-1:0] GATE_RST = FRAC'((64'd8388600 << FRAC) >> 23);

    t_state r_state, n_state;
    logic   w_div_start;
    logic   w_div_busy;

    logic [SAMPLE_BITS-1:0] dly_mem [WIN];
    logic [FRAC-1:0]        tree_mem [TD];

    logic [FRAC-1:0]        r_gate;
    logic                   r_active;
    logic [L-1:0]           r_wpos;
    logic [GW-1:0]          r_applied, r_smooth;
    logic [SAMPLE_BITS-1:0] r_in;
    logic [FRAC-1:0]        r_m;
    logic [NW-1:0]          r_node;
    logic [LW-1:0]          r_lvl;
    logic [NW-1:0]          r_clr;
    logic                   r_clr_done;
    logic [FRAC-1:0]        r_sib;
    logic [GW-1:0]          r_target;
    logic [GW-1:0]          r_rel;
    logic [PW-1:0]          r_acc;
    logic [PW-1:0]          r_prod;
    logic [SAMPLE_BITS-1:0] r_d;
    logic [GW-1:0]          r_md;
    logic [GW-1:0]          r_g;
    logic [GW:0]            r_p;
    logic [SAMPLE_BITS-1:0] r_out;
    logic                   r_ovalid;
    logic                   r_div_go;

    // single shared multiplier, operands picked by state, product registered
    logic [GW-1:0]      w_mul_a;
    logic [BW-1:0]      w_mul_b;
    logic [PW-1:0]      w_mul;
    logic [2*FRAC-1:0]  w_quot;
    logic [FRAC-1:0]    w_div_num;
    logic [FRAC:0]      w_div_den;

    logic               w_acc;
    logic [SAMPLE_BITS-1:0] w_in_mag;
    logic [FRAC-1:0]    w_in_magc;

    assign w_acc    = s_axis_tvalid && s_axis_tready;
    assign w_in_mag = s_axis_tdata[SAMPLE_BITS-1] ? (~s_axis_tdata + 1'b1) : s_axis_tdata;
    assign w_in_magc = w_in_mag[FRAC] ? MAG_MAX : w_in_mag[FRAC-1:0];

    always_comb begin
        w_mul_a = r_md;
        w_mul_b = BW'(r_g);
        case (r_state)
            ST_MREL: begin
                w_mul_a = r_applied;
                w_mul_b = BW'(COEF_REL_KEEP);
            end
            ST_MTGT1: begin
                w_mul_a = r_target;
                w_mul_b = BW'(COEF_TGT_NEW);
            end
            ST_MTGT2: begin
                w_mul_a = r_smooth;
                w_mul_b = BW'(COEF_TGT_KEEP);
            end
            default: ;
        endcase
    end
    assign w_mul = PW'(w_mul_a) * PW'(w_mul_b);

    assign w_div_num = r_gate;
    assign w_div_den = (r_state == ST_DIV2) ? r_md : {1'b0, r_m};

    lpl_div #(.FRAC(FRAC)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    logic [FRAC-1:0] w_treemax;
    assign w_treemax = (r_sib > r_m) ? r_sib : r_m;

    // smoothing: release term, leaky target, then the lower of the two, capped at unity
    localparam logic [PW:0] HALF = (PW+1)'(1) << (COEF_SHIFT - 1);
    localparam logic [PW:0] REL_ADD =
        (((PW+1)'(UNITY) * (PW+1)'(COEF_REL_ADD)) + HALF) >> COEF_SHIFT;
    logic [PW:0] w_rel_full, w_tgt, w_g0w;
    logic [GW-1:0] w_g0;
    assign w_rel_full = (({1'b0, r_prod} + HALF) >> COEF_SHIFT) + REL_ADD;
    assign w_tgt = ({1'b0, r_acc} + {1'b0, r_prod} + HALF) >> COEF_SHIFT;
    assign w_g0w = (w_tgt < (PW+1)'(r_rel)) ? w_tgt : (PW+1)'(r_rel);
    assign w_g0  = (w_g0w > (PW+1)'(UNITY)) ? UNITY : w_g0w[GW-1:0];

    logic [GW:0] w_pr;
    assign w_pr = (GW+1)'((r_prod + (PW'(1) << (FRAC - 1))) >> FRAC);

    logic [2*FRAC-1:0] w_q2;
    assign w_q2 = (w_quot > (2*FRAC)'(UNITY)) ? (2*FRAC)'(UNITY) : w_quot;

    logic [GW:0] w_pneg;
    assign w_pneg = (r_p > (GW+1)'(UNITY)) ? (GW+1)'(UNITY) : r_p;

    // sequencer: next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!r_clr_done) n_state = ST_CLEAR;
                else if (w_acc) begin
                    if (r_active || w_in_magc >= r_gate)
                        n_state = r_active ? ST_TREE_RD : ST_CLEAR;
                    else n_state = ST_MREL;
                end
            end
            ST_CLEAR: if (r_clr == NW'(TD - 1))
                n_state = r_clr_done ? ST_TREE_RD : ST_IDLE;
            ST_TREE_RD:  n_state = ST_TREE_CMP;
            ST_TREE_CMP: if (r_lvl == LW'(L - 1))
                n_state = (w_treemax > r_gate) ? ST_DIV1 : ST_MREL;
                else n_state = ST_TREE_RD;
            ST_DIV1:   if (!r_div_go && !w_div_busy) n_state = ST_MREL;
            ST_MREL:   n_state = ST_MTGT1;
            ST_MTGT1:  n_state = ST_MTGT2;
            ST_MTGT2:  n_state = ST_SMOOTH;
            ST_SMOOTH: n_state = ST_SCALE;
            ST_SCALE:  n_state = ST_CHECK;
            ST_CHECK:  n_state = (w_pr >= {2'b0, r_gate} && r_md != '0) ? ST_DIV2 : ST_OUT;
            ST_DIV2:   if (!r_div_go && !w_div_busy) n_state = ST_SCALE2;
            ST_SCALE2: n_state = ST_ROUND2;
            ST_ROUND2: n_state = ST_OUT;
            ST_OUT:    if (!r_ovalid) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb begin
        w_div_start   = r_div_go;
        s_axis_tready = (r_state == ST_IDLE) && r_clr_done;
        o_cfg_ready   = (r_state == ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_gate     <= GATE_RST;
            r_active   <= 1'b0;
            r_wpos     <= '0;
            r_applied  <= UNITY;
            r_smooth   <= UNITY;
            r_clr      <= '0;
            r_clr_done <= 1'b0;
            r_ovalid   <= 1'b0;
            r_div_go   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_div_go <= 1'b0;
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) r_gate <= i_cfg_data;
            case (r_state)
                ST_IDLE: if (w_acc) begin
                    r_in     <= s_axis_tdata;
                    r_m      <= w_in_magc;
                    r_node   <= NW'(WIN) + NW'(r_wpos);
                    r_lvl    <= '0;
                    r_target <= UNITY;
                    if (r_active || w_in_magc >= r_gate) r_active <= 1'b1;
                    r_clr    <= '0;
                end
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == NW'(TD - 1)) r_clr_done <= 1'b1;
                end
                ST_TREE_CMP: begin
                    r_m    <= w_treemax;
                    r_node <= r_node >> 1;
                    r_lvl  <= r_lvl + 1'b1;
                    if (r_lvl == LW'(L - 1)) begin
                        if (w_treemax > r_gate) r_div_go <= 1'b1;
                        else r_active <= 1'b0;
                    end
                end
                ST_DIV1: if (!r_div_go && !w_div_busy) r_target <= GW'(w_quot);
                ST_MTGT1: r_rel <= w_rel_full[GW-1:0];
                ST_MTGT2: r_acc <= r_prod;
                ST_SMOOTH: begin
                    r_smooth <= w_tgt[GW-1:0];
                    r_g      <= w_g0;
                end
                ST_CHECK: begin
                    r_p <= w_pr;
                    if (w_pr >= {2'b0, r_gate}) begin
                        if (r_md != '0) r_div_go <= 1'b1;
                        else r_g <= UNITY;
                    end
                end
                ST_DIV2: if (!r_div_go && !w_div_busy) r_g <= GW'(w_q2);
                ST_ROUND2: r_p <= w_pr;
                ST_OUT: if (!r_ovalid) begin
                    r_applied <= r_g;
                    r_ovalid  <= 1'b1;
                    r_wpos    <= r_wpos + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // product register, sibling read and output register
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul;
        if (r_state == ST_TREE_RD) r_sib <= tree_mem[r_node ^ NW'(1)];
        if (r_state == ST_OUT && !r_ovalid)
            r_out <= r_d[SAMPLE_BITS-1] ? SAMPLE_BITS'(~w_pneg + 1'b1)
                   : SAMPLE_BITS'((r_p > (GW+1)'(MAG_MAX)) ? (GW+1)'(MAG_MAX) : r_p);
    end

    // memories; the pass after reset also clears the delay line
    logic [SAMPLE_BITS-1:0] r_dq;
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR)
            tree_mem[r_clr] <= '0;
        else if (r_state == ST_TREE_RD)
            tree_mem[r_node] <= r_m;
        if (r_state == ST_CLEAR && !r_clr_done)
            dly_mem[r_clr[L-1:0]] <= '0;
        else if (r_state == ST_SMOOTH)
            dly_mem[r_wpos] <= r_in;
        r_dq <= dly_mem[r_wpos + 1'b1];
        if (r_state == ST_SCALE) begin
            r_d <= r_dq;
        end
    end

    // magnitude of delayed sample; read captured at SMOOTH, used from SCALE
    logic [SAMPLE_BITS-1:0] w_dneg;
    assign w_dneg = ~r_dq + 1'b1;
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SMOOTH)
            r_md <= r_dq[SAMPLE_BITS-1] ? GW'(w_dneg) : GW'(r_dq);
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;

    a_gain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |-> (r_g <= UNITY))
        else $error("applied gain above unity");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_axis_tready)
        else $error("ready while busy");
    a_div_one_shot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_go |=> !r_div_go)
        else $error("divider start held");
    a_wpos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> r_wpos == $past(r_wpos) + 1'b1)
        else $error("write position not advanced");
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Limiter testbench: drives samples in bursts, predicts each limited output
// with a bit-accurate fixed-point model and checks the output stream in order.
// ---------------------------------------------------------------------------

class limiter_scoreboard;
    localparam int FRAC = 23;
    localparam longint UNITY_G = 64'd1 << FRAC;
    localparam longint MAGMAX = UNITY_G - 1;

    longint         dly[256];
    longint unsigned tree[512];
    int             wpos;
    bit             limiting;
    longint unsigned gain_now;
    longint unsigned tgt_smooth;
    longint unsigned gate;
    logic [23:0]    pending[$];
    int             n_err;

    function void reset_state();
        foreach (dly[k]) dly[k] = 0;
        foreach (tree[k]) tree[k] = 0;
        wpos = 0;
        limiting = 0;
        gain_now = UNITY_G;
        tgt_smooth = UNITY_G;
        gate = 64'd8388600;
        pending.delete();
        n_err = 0;
    endfunction

    function longint unsigned scale(longint unsigned m, longint unsigned g);
        return (m * g + (UNITY_G >> 1)) >> FRAC;
    endfunction

    function void note_sample(logic signed [23:0] x);
        longint s, d;
        longint unsigned mag, magc, target, rel, tg, g, md, p, m, sib;
        int node;
        logic [23:0] res;
        s = x;
        target = UNITY_G;
        mag = s < 0 ? -s : s;
        magc = mag > MAGMAX ? MAGMAX : mag;
        if (limiting || magc >= gate) begin
            if (!limiting) foreach (tree[k]) tree[k] = 0;
            limiting = 1;
            node = 256 + wpos;
            m = magc;
            for (int l = 0; l < 8; l++) begin
                tree[node] = m;
                sib = tree[node ^ 1];
                if (sib > m) m = sib;
                node = node >> 1;
            end
            if (m > gate) target = (gate << FRAC) / m;
            else limiting = 0;
        end
        dly[wpos] = s;
        wpos = (wpos + 1) & 255;
        d = dly[wpos];
        rel = ((gain_now * lpl_pkg::COEF_REL_KEEP + (64'd1 << 23)) >> 24)
            + ((UNITY_G * lpl_pkg::COEF_REL_ADD + (64'd1 << 23)) >> 24);
        tg = (target * lpl_pkg::COEF_TGT_NEW + tgt_smooth * lpl_pkg::COEF_TGT_KEEP
            + (64'd1 << 23)) >> 24;
        tgt_smooth = tg;
        g = tg < rel ? tg : rel;
        if (g > UNITY_G) g = UNITY_G;
        md = d < 0 ? -d : d;
        p = scale(md, g);
        if (p >= gate) begin
            if (md != 0) begin
                g = (gate << FRAC) / md;
                if (g > UNITY_G) g = UNITY_G;
            end else begin
                g = UNITY_G;
            end
            p = scale(md, g);
        end
        gain_now = g;
        if (d < 0) begin
            if (p > UNITY_G) p = UNITY_G;
            res = 24'(-p);
        end else begin
            if (p > MAGMAX) p = MAGMAX;
            res = 24'(p);
        end
        pending.push_back(res);
    endfunction

    function void check_output(logic [23:0] got);
        logic [23:0] want;
        if (pending.size() == 0) begin
            n_err++;
            if (n_err <= 10) $display("unexpected output %0d", $signed(got));
            return;
        end
        want = pending.pop_front();
        if (got !== want) begin
            n_err++;
            if (n_err <= 10)
                $display("sample_out mismatch: expected %0d got %0d",
                         $signed(want), $signed(got));
        end
    endfunction
endclass

module tb_top;
    import lpl_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // [23:0] sample_in
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // [23:0] sample_out
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [22:0] i_cfg_data;

    limiter_scoreboard sb;
    int  stall_mode;     // 0 random pattern, 1 long hold-off, 2 always ready
    int  cycles;

    lookahead_peak_limiter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver: check on accepted transactions, stall pattern by mode
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_output(m_axis_tdata);
        case (stall_mode)
            0: m_axis_tready <= ($urandom_range(0, 3) != 0);
            1: m_axis_tready <= 1'b0;
            default: m_axis_tready <= 1'b1;
        endcase
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 20000000) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_sample(logic [23:0] x);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_sample(x);
    endtask

    task automatic idle_sender(int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_gate(logic [22:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.gate = v;
    endtask

    function automatic logic [23:0] rand_sample(int loud);
        case ($urandom_range(0, 5))
            0: return 24'($urandom);
            1: return loud ? 24'h800000 : 24'h7fffff;
            default: return loud ? 24'($urandom_range(0, 1) ? $urandom_range(7000000, 8388607)
                                    : -$urandom_range(7000000, 8388608))
                                 : 24'($signed($urandom_range(0, 4000000)) - 2000000);
        endcase
    endfunction

    task automatic random_phase(int n);
        int left, burst;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && left > 0; k++, left--)
                send_sample(rand_sample($urandom_range(0, 3) == 0));
            if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 30));
        end
    endtask

    initial begin
        logic [23:0] dir[$];
        sb = new();
        sb.reset_state();
        stall_mode = 2;
        cycles = 0;
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        m_axis_tready = 0;
        i_cfg_valid = 0;
        i_cfg_data = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, gate trigger, full-scale negative, zeros
        dir = '{24'h000000, 24'h7fffff, 24'h800000, 24'h000001, 24'hffffff,
                24'h7ffff8, 24'h7ffff7, 24'h800008, 24'h400000, 24'hc00000,
                24'h555555, 24'haaaaaa, 24'h000000, 24'h7fffff, 24'h800001};
        foreach (dir[k]) send_sample(dir[k]);
        drain();

        // smallest gate so the limiter triggers often on tiny samples
        write_gate(23'd1);
        for (int k = 0; k < 10; k++) send_sample(k[0] ? 24'h000002 : 24'h000000);
        drain();
        write_gate(23'h7fffff);
        for (int k = 0; k < 5; k++) send_sample(24'h800000);
        drain();

        stall_mode = 0;
        write_gate(23'd4000000);
        random_phase(500);
        drain();

        // long receiver hold-off while the sender keeps offering
        fork
            begin
                stall_mode = 1;
                repeat (3000) @(posedge i_clk);
                stall_mode = 0;
            end
            random_phase(60);
        join
        drain();

        write_gate(23'($urandom_range(1, 8388607)));
        random_phase(500);
        drain();
        write_gate(23'd8388600);
        stall_mode = 2;
        random_phase(300);
        stall_mode = 0;
        random_phase(300);
        drain();

        if (sb.n_err == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
